// File: src/knn_pkg.sv
// Shared types and constants for the k-nearest-neighbor classifier.
`timescale 1ns / 1ps
package knn_pkg;

    localparam int POS_W       = 10;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        CMD_TRAIN  = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_TRAIN = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t         kind;
        logic             last;
        logic [POS_W-1:0] pos;
        logic [7:0]       feature;
        logic [3:0]       label;
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_SEL,
        ST_VOTE,
        ST_OUT
    } back_state_t;

    typedef enum logic {
        REG_NEIGHBOUR_COUNT = 1'b0,
        REG_VECTOR_LENGTH   = 1'b1
    } reg_index_t;

endpackage

// File: src/knn_if.sv
// Valid/ready channel interfaces for input items and results.
`timescale 1ns / 1ps
interface knn_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] feature;
    logic [3:0] label;

    modport source (output valid, cmd, feature, label, input ready);
    modport sink (input valid, cmd, feature, label, output ready);
endinterface

interface knn_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] predicted_class;
    logic [4:0] votes;
    logic       status;

    modport source (output valid, predicted_class, votes, status, input ready);
    modport sink (input valid, predicted_class, votes, status, output ready);
endinterface

// File: src/knn_fifo.sv
// Short operation queue between the front and back parts.
`timescale 1ns / 1ps
module knn_fifo
    import knn_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         full,
    output logic         empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem[rd_ptr_reg];
    assign full  = (32'(count_reg) == QUEUE_DEPTH);
    assign empty = (count_reg == '0);

endmodule

// File: src/knn_front.sv
// Front part: accepts items, tracks the feature position, queues operations.
`timescale 1ns / 1ps
module knn_front
    import knn_pkg::*;
#(
    parameter int MAX_FEATURES = 64
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    knn_in_if.sink                             in_ch,
    input  logic [$clog2(MAX_FEATURES+1)-1:0]  len,
    output op_t                                q_din,
    output logic                               q_push,
    input  logic                               q_full
);

    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

    logic [FW-1:0] pos_reg, pos_next;
    logic          accept;
    logic          last;
    cmd_t          cmd;

    assign cmd         = cmd_t'(in_ch.cmd);
    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign last        = (32'(pos_reg) + 1 >= 32'(len));

    always_comb
    begin
        pos_next        = pos_reg;
        q_push          = 1'b0;
        q_din.kind      = OP_CLEAR;
        q_din.last      = last;
        q_din.pos       = POS_W'(pos_reg);
        q_din.feature   = in_ch.feature;
        q_din.label     = in_ch.label;
        case (cmd)
            CMD_TRAIN:
            begin
                q_din.kind = OP_TRAIN;
                q_push     = accept;
                if (accept)
                begin
                    pos_next = last ? '0 : pos_reg + FW'(1);
                end
            end
            CMD_QUERY:
            begin
                q_din.kind = OP_QUERY;
                q_push     = accept;
                if (accept)
                begin
                    pos_next = last ? '0 : pos_reg + FW'(1);
                end
            end
            CMD_CLEAR:
            begin
                q_din.kind = OP_CLEAR;
                q_push     = accept;
                if (accept)
                begin
                    pos_next = '0;
                end
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// File: src/knn_back.sv
// Back part: sample store, distance walk, k selection passes and vote.
`timescale 1ns / 1ps
module knn_back
    import knn_pkg::*;
#(
    parameter int MAX_SAMPLES  = 1024,
    parameter int MAX_FEATURES = 64,
    parameter int MAX_K        = 16,
    parameter int NUM_CLASSES  = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  op_t                                q_dout,
    input  logic                               q_empty,
    output logic                               q_pop,
    input  logic [$clog2(MAX_FEATURES+1)-1:0]  len,
    input  logic [$clog2(MAX_K+1)-1:0]         kcfg,
    knn_out_if.source                          out_ch
);

    localparam int SW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int KW  = $clog2(MAX_K + 1);
    localparam int CLW = $clog2(NUM_CLASSES);
    localparam int DW  = 16 + FW;
    localparam int TD  = MAX_SAMPLES * (2 ** FW);
    localparam logic [8:0] NC_M1 = 9'(NUM_CLASSES - 1);

    logic [7:0]     train_mem [TD];
    logic [CLW-1:0] label_mem [MAX_SAMPLES];
    logic [DW-1:0]  dist_mem  [MAX_SAMPLES];
    logic [7:0]     qbuf_mem  [MAX_FEATURES];

    back_state_t state_reg, state_next;
    logic [CW-1:0]  stored_reg, stored_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [KW-1:0]  pass_reg, pass_next;

    logic [SW-1:0]  iss_si_reg, iss_si_next;
    logic [FW-1:0]  iss_fj_reg, iss_fj_next;
    logic           iss_done_reg, iss_done_next;
    logic           p1_v_reg, p1_v_next, p1_first_reg, p1_last_reg;
    logic [SW-1:0]  p1_si_reg;
    logic           p2_v_reg, p2_v_next, p2_first_reg, p2_last_reg;
    logic [SW-1:0]  p2_si_reg;
    logic [15:0]    sq_reg, sq_next;
    logic [DW-1:0]  acc_reg, acc_next, dsum;
    logic [7:0]     tf_rd_reg, qb_rd_reg, diff;

    logic [SW-1:0]  sel_i_reg, sel_i_next;
    logic           sel_done_reg, sel_done_next;
    logic           s1_v_reg, s1_v_next;
    logic [SW-1:0]  s1_i_reg;
    logic [DW-1:0]  dist_rd_reg;
    logic [CLW-1:0] lab_rd_reg;
    logic           found_reg, found_next, have_last_reg, have_last_next;
    logic [DW-1:0]  best_d_reg, best_d_next, last_d_reg, last_d_next;
    logic [SW-1:0]  best_i_reg, best_i_next, last_i_reg, last_i_next;
    logic [CLW-1:0] best_lab_reg, best_lab_next;
    logic           eligible, better;

    logic [KW-1:0]  vote_reg [NUM_CLASSES];
    logic [KW-1:0]  vote_next [NUM_CLASSES];
    logic [CLW-1:0] vc_i_reg, vc_i_next, win_c_reg, win_c_next;
    logic [KW-1:0]  win_v_reg, win_v_next;

    logic           out_v_reg, out_v_next, ost_reg, ost_next;
    logic [CLW-1:0] ocls_reg, ocls_next;
    logic [KW-1:0]  ovotes_reg, ovotes_next;

    logic           tr_we, lab_we, qb_we, dist_we;
    logic [8:0]     lab_ext;
    logic [CLW-1:0] lab_sat;
    logic           out_free;

    assign lab_ext  = {5'b0, q_dout.label};
    assign lab_sat  = (lab_ext >= NC_M1) ? CLW'(NC_M1) : CLW'(lab_ext);
    assign diff     = (qb_rd_reg > tf_rd_reg) ? qb_rd_reg - tf_rd_reg : tf_rd_reg - qb_rd_reg;
    assign dsum     = (p2_first_reg ? '0 : acc_reg) + DW'(sq_reg);
    assign out_free = !out_v_reg || out_ch.ready;
    assign eligible = !have_last_reg || (dist_rd_reg > last_d_reg)
                      || ((dist_rd_reg == last_d_reg) && (s1_i_reg > last_i_reg));
    assign better   = !found_reg || (dist_rd_reg < best_d_reg);

    always_comb
    begin
        state_next     = state_reg;
        stored_next    = stored_reg;
        k_next         = k_reg;
        pass_next      = pass_reg;
        iss_si_next    = iss_si_reg;
        iss_fj_next    = iss_fj_reg;
        iss_done_next  = iss_done_reg;
        p1_v_next      = 1'b0;
        p2_v_next      = p1_v_reg;
        sq_next        = {8'b0, diff} * {8'b0, diff};
        acc_next       = acc_reg;
        sel_i_next     = sel_i_reg;
        sel_done_next  = sel_done_reg;
        s1_v_next      = 1'b0;
        found_next     = found_reg;
        have_last_next = have_last_reg;
        best_d_next    = best_d_reg;
        best_i_next    = best_i_reg;
        best_lab_next  = best_lab_reg;
        last_d_next    = last_d_reg;
        last_i_next    = last_i_reg;
        vote_next      = vote_reg;
        vc_i_next      = vc_i_reg;
        win_c_next     = win_c_reg;
        win_v_next     = win_v_reg;
        out_v_next     = out_v_reg;
        ost_next       = ost_reg;
        ocls_next      = ocls_reg;
        ovotes_next    = ovotes_reg;
        q_pop          = 1'b0;
        tr_we          = 1'b0;
        lab_we         = 1'b0;
        qb_we          = 1'b0;
        dist_we        = 1'b0;

        if (out_v_reg && out_ch.ready)
        begin
            out_v_next = 1'b0;
        end

        if (p2_v_reg)
        begin
            if (p2_last_reg)
            begin
                dist_we = 1'b1;
            end
            else
            begin
                acc_next = dsum;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_dout.kind)
                        OP_TRAIN:
                        begin
                            if (32'(stored_reg) < MAX_SAMPLES)
                            begin
                                tr_we = 1'b1;
                                if (q_dout.last)
                                begin
                                    lab_we      = 1'b1;
                                    stored_next = stored_reg + CW'(1);
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            qb_we = 1'b1;
                            if (q_dout.last)
                            begin
                                if (stored_reg == '0)
                                begin
                                    win_c_next = '0;
                                    win_v_next = '0;
                                    state_next = ST_OUT;
                                end
                                else
                                begin
                                    k_next        = (32'(stored_reg) < 32'(kcfg))
                                                    ? KW'(stored_reg) : kcfg;
                                    iss_si_next   = '0;
                                    iss_fj_next   = '0;
                                    iss_done_next = 1'b0;
                                    state_next    = ST_DIST;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            stored_next = '0;
                        end
                        default:
                        begin
                            stored_next = stored_reg;
                        end
                    endcase
                end
            end
            ST_DIST:
            begin
                if (!iss_done_reg)
                begin
                    p1_v_next = 1'b1;
                    if (32'(iss_fj_reg) + 1 == 32'(len))
                    begin
                        iss_fj_next = '0;
                        if (32'(iss_si_reg) + 1 == 32'(stored_reg))
                        begin
                            iss_done_next = 1'b1;
                        end
                        else
                        begin
                            iss_si_next = iss_si_reg + SW'(1);
                        end
                    end
                    else
                    begin
                        iss_fj_next = iss_fj_reg + FW'(1);
                    end
                end
                else if (!p1_v_reg && !p2_v_reg)
                begin
                    for (int c = 0; c < NUM_CLASSES; c++)
                    begin
                        vote_next[c] = '0;
                    end
                    pass_next      = '0;
                    have_last_next = 1'b0;
                    found_next     = 1'b0;
                    sel_i_next     = '0;
                    sel_done_next  = 1'b0;
                    state_next     = ST_SEL;
                end
            end
            ST_SEL:
            begin
                if (!sel_done_reg)
                begin
                    s1_v_next = 1'b1;
                    if (32'(sel_i_reg) + 1 == 32'(stored_reg))
                    begin
                        sel_done_next = 1'b1;
                    end
                    else
                    begin
                        sel_i_next = sel_i_reg + SW'(1);
                    end
                end
                if (s1_v_reg && eligible && better)
                begin
                    found_next    = 1'b1;
                    best_d_next   = dist_rd_reg;
                    best_i_next   = s1_i_reg;
                    best_lab_next = lab_rd_reg;
                end
                if (sel_done_reg && !s1_v_reg)
                begin
                    vote_next[best_lab_reg] = vote_reg[best_lab_reg] + KW'(1);
                    last_d_next    = best_d_reg;
                    last_i_next    = best_i_reg;
                    have_last_next = 1'b1;
                    found_next     = 1'b0;
                    sel_i_next     = '0;
                    sel_done_next  = 1'b0;
                    pass_next      = pass_reg + KW'(1);
                    if (32'(pass_reg) + 1 == 32'(k_reg))
                    begin
                        vc_i_next  = '0;
                        win_c_next = '0;
                        win_v_next = '0;
                        state_next = ST_VOTE;
                    end
                end
            end
            ST_VOTE:
            begin
                if (vote_reg[vc_i_reg] > win_v_reg)
                begin
                    win_v_next = vote_reg[vc_i_reg];
                    win_c_next = vc_i_reg;
                end
                if (32'(vc_i_reg) + 1 == NUM_CLASSES)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    vc_i_next = vc_i_reg + CLW'(1);
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    // a classified query always has at least one vote
                    out_v_next  = 1'b1;
                    ost_next    = (win_v_reg == '0);
                    ocls_next   = win_c_reg;
                    ovotes_next = win_v_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            stored_reg <= '0;
            out_v_reg  <= 1'b0;
            p1_v_reg   <= 1'b0;
            p2_v_reg   <= 1'b0;
            s1_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            stored_reg <= stored_next;
            out_v_reg  <= out_v_next;
            p1_v_reg   <= p1_v_next;
            p2_v_reg   <= p2_v_next;
            s1_v_reg   <= s1_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        pass_reg      <= pass_next;
        iss_si_reg    <= iss_si_next;
        iss_fj_reg    <= iss_fj_next;
        iss_done_reg  <= iss_done_next;
        p1_first_reg  <= (iss_fj_reg == '0);
        p1_last_reg   <= (32'(iss_fj_reg) + 1 == 32'(len));
        p1_si_reg     <= iss_si_reg;
        p2_first_reg  <= p1_first_reg;
        p2_last_reg   <= p1_last_reg;
        p2_si_reg     <= p1_si_reg;
        sq_reg        <= sq_next;
        acc_reg       <= acc_next;
        sel_i_reg     <= sel_i_next;
        sel_done_reg  <= sel_done_next;
        s1_i_reg      <= sel_i_reg;
        found_reg     <= found_next;
        have_last_reg <= have_last_next;
        best_d_reg    <= best_d_next;
        best_i_reg    <= best_i_next;
        best_lab_reg  <= best_lab_next;
        last_d_reg    <= last_d_next;
        last_i_reg    <= last_i_next;
        vote_reg      <= vote_next;
        vc_i_reg      <= vc_i_next;
        win_c_reg     <= win_c_next;
        win_v_reg     <= win_v_next;
        ost_reg       <= ost_next;
        ocls_reg      <= ocls_next;
        ovotes_reg    <= ovotes_next;
    end

    always_ff @(posedge clk)
    begin
        if (tr_we)
        begin
            train_mem[{stored_reg[SW-1:0], q_dout.pos[FW-1:0]}] <= q_dout.feature;
        end
        tf_rd_reg <= train_mem[{iss_si_reg, iss_fj_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (lab_we)
        begin
            label_mem[stored_reg[SW-1:0]] <= lab_sat;
        end
        lab_rd_reg <= label_mem[sel_i_reg];
    end

    always_ff @(posedge clk)
    begin
        if (qb_we)
        begin
            qbuf_mem[q_dout.pos[FW-1:0]] <= q_dout.feature;
        end
        qb_rd_reg <= qbuf_mem[iss_fj_reg];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[p2_si_reg] <= dsum;
        end
        dist_rd_reg <= dist_mem[sel_i_reg];
    end

    assign out_ch.valid           = out_v_reg;
    assign out_ch.predicted_class = 4'(ocls_reg);
    assign out_ch.votes           = 5'(ovotes_reg);
    assign out_ch.status          = ost_reg;

endmodule

// File: src/knn_classifier_unit.sv
// Top level of the k-nearest-neighbor classifier with its APB register port.
//
// in_ch carries one item per transfer: cmd 0 stores a training feature (the
// label is taken with the last feature of a vector), cmd 1 a query feature,
// cmd 2 empties the training store. The last feature of a query produces one
// result on out_ch: the majority label among the k nearest samples by squared
// Euclidean distance, its vote count, and status 1 if the store is empty.
// Training, clear and non-final query items pass through the front; a
// four-entry queue holds them for the back, which executes one per cycle
// while idle. For a final query feature the back walks the stored samples
// through the single read port of the training memory, then reads one
// distance per cycle in each of k selection passes and counts the votes.
// Up to four items are still accepted while the back works.
// The result sits in an output register; while out_ch stalls, the back keeps
// draining queued items and only waits before issuing a new result.
// Reset empties the store, zeroes the feature position, k = 3, length = 64.
// Registers: 0x0 neighbour_count, 0x4 vector_length; write only when idle.
`timescale 1ns / 1ps
module knn_classifier_unit
    import knn_pkg::*;
#(
    parameter int MAX_SAMPLES  = 1024,
    parameter int MAX_FEATURES = 64,
    parameter int MAX_K        = 16,
    parameter int NUM_CLASSES  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    knn_in_if.sink      in_ch,
    knn_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW = $clog2(MAX_FEATURES + 1);
    localparam int KW = $clog2(MAX_K + 1);

    logic [4:0]    nc_reg;
    logic [6:0]    vl_reg;
    logic          wr_en;
    reg_index_t    widx;
    logic [LW-1:0] len;
    logic [KW-1:0] kcfg;

    op_t  q_din, q_dout;
    logic q_push, q_pop, q_full, q_empty;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign widx   = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg <= 5'd3;
            vl_reg <= 7'd64;
        end
        else if (wr_en)
        begin
            case (widx)
                REG_NEIGHBOUR_COUNT: nc_reg <= pwdata[4:0];
                REG_VECTOR_LENGTH:   vl_reg <= pwdata[6:0];
                default:             nc_reg <= nc_reg;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_NEIGHBOUR_COUNT: prdata = {27'b0, nc_reg};
            REG_VECTOR_LENGTH:   prdata = {25'b0, vl_reg};
            default:             prdata = '0;
        endcase
    end

    always_comb
    begin
        if (vl_reg == '0)
        begin
            len = LW'(1);
        end
        else if (32'(vl_reg) > MAX_FEATURES)
        begin
            len = LW'(MAX_FEATURES);
        end
        else
        begin
            len = LW'(vl_reg);
        end
        if (nc_reg == '0)
        begin
            kcfg = KW'(1);
        end
        else if (32'(nc_reg) > MAX_K)
        begin
            kcfg = KW'(MAX_K);
        end
        else
        begin
            kcfg = KW'(nc_reg);
        end
    end

    knn_front #(
        .MAX_FEATURES (MAX_FEATURES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .len    (len),
        .q_din  (q_din),
        .q_push (q_push),
        .q_full (q_full)
    );

    knn_fifo #(
        .W ($bits(op_t))
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    knn_back #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_K        (MAX_K),
        .NUM_CLASSES  (NUM_CLASSES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_dout  (q_dout),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .len     (len),
        .kcfg    (kcfg),
        .out_ch  (out_ch)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("queue popped while empty");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status) |-> (out_ch.votes == '0 && out_ch.predicted_class == '0))
        else $error("empty-store result carries votes");

    a_ok_has_votes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.status) |-> (out_ch.votes != '0))
        else $error("classified result without votes");

endmodule
